// ----- rtl/core/pol_pkg.sv -----
// Package for the positional ordered list: sizes, operation and status codes,
// and the request, response and cell command types.
// No dependencies.
`default_nettype none

package pol_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 7;
    localparam int VAL_W    = 32;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_REM_FRONT = 3'd3;
    localparam logic [2:0] OP_REM_BACK  = 3'd4;
    localparam logic [2:0] OP_REM_AT    = 3'd5;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_NOPOS = 2'd3
    } t_status;

    typedef struct packed {
        logic [2:0]              operation;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] removed_value;
        logic                    removed_valid;
        logic [LEN_W-1:0]        list_length;
    } t_rsp;

    // Broadcast to every cell in the cycle a request is taken.
    typedef struct packed {
        logic             ins;
        logic             rem;
        logic [CMP_W-1:0] idx;
    } t_cmd;

endpackage

`default_nettype wire

// ----- rtl/core/pol_cell.sv -----
// One storage cell of the list chain: holds one entry and moves it toward
// or away from the front. Depends on pol_pkg.
`default_nettype none

module pol_cell (
    input  wire logic                             i_clk,
    input  wire pol_pkg::t_cmd                    i_cmd,
    input  wire logic [pol_pkg::CMP_W-1:0]        i_pos,
    input  wire logic signed [pol_pkg::VAL_W-1:0] i_new,
    input  wire logic signed [pol_pkg::VAL_W-1:0] i_left,
    input  wire logic signed [pol_pkg::VAL_W-1:0] i_right,
    output logic signed [pol_pkg::VAL_W-1:0]      o_val,
    output logic signed [pol_pkg::VAL_W-1:0]      o_tap
);
    import pol_pkg::*;

    logic signed [VAL_W-1:0] r_val;
    logic signed [VAL_W-1:0] n_val;

    always_comb begin
        n_val = r_val;
        if (i_cmd.ins) begin
            if (i_pos == i_cmd.idx) begin
                n_val = i_new;
            end else if (i_pos > i_cmd.idx) begin
                n_val = i_left;
            end
        end else if (i_cmd.rem) begin
            if (i_pos >= i_cmd.idx) begin
                n_val = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;
    // Only the cell being removed puts its entry on the OR bus.
    assign o_tap = (i_cmd.rem && (i_pos == i_cmd.idx)) ? r_val : '0;

endmodule

`default_nettype wire

// ----- rtl/core/pol_ctrl.sv -----
// Request decoder and length counter for the list chain: checks each request
// against the length, drives the cell command and registers the response.
// Depends on pol_pkg.
`default_nettype none

module pol_ctrl (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_accept,
    input  wire pol_pkg::t_req                    i_req,
    input  wire logic signed [pol_pkg::VAL_W-1:0] i_tap,
    output pol_pkg::t_cmd                         o_cmd,
    output logic                                  o_strobe,
    output pol_pkg::t_rsp                         o_rsp
);
    import pol_pkg::*;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             r_strobe;
    t_rsp             r_rsp;
    t_rsp             n_rsp;

    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] idx;
    t_status          status;
    logic             do_ins;
    logic             do_rem;

    assign cnt_x = CMP_W'(r_count);
    assign pos_x = CMP_W'(i_req.position);

    always_comb begin
        idx    = '0;
        status = ST_DONE;
        do_ins = 1'b0;
        do_rem = 1'b0;
        unique case (i_req.operation) inside
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT: begin
                if (i_req.operation == OP_INS_BACK) begin
                    idx = cnt_x;
                end else if (i_req.operation == OP_INS_AT) begin
                    idx = pos_x;
                end
                if (r_count >= CNT_W'(CAPACITY)) begin
                    status = ST_FULL;
                end else if (idx > cnt_x) begin
                    status = ST_NOPOS;
                end else begin
                    do_ins = 1'b1;
                end
            end
            OP_REM_FRONT, OP_REM_BACK, OP_REM_AT: begin
                if (i_req.operation == OP_REM_BACK) begin
                    idx = cnt_x - CMP_W'(1);
                end else if (i_req.operation == OP_REM_AT) begin
                    idx = pos_x;
                end
                if (r_count == '0) begin
                    status = ST_EMPTY;
                end else if (idx >= cnt_x) begin
                    status = ST_NOPOS;
                end else begin
                    do_rem = 1'b1;
                end
            end
            default: begin
                // Unused operation codes leave the list alone.
                status = ST_DONE;
            end
        endcase
    end

    assign o_cmd.ins = i_accept && do_ins;
    assign o_cmd.rem = i_accept && do_rem;
    assign o_cmd.idx = idx;

    always_comb begin
        n_count = r_count;
        if (do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
        n_rsp.status        = status;
        n_rsp.removed_value = do_rem ? i_tap : '0;
        n_rsp.removed_valid = do_rem;
        n_rsp.list_length   = LEN_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_accept;
            if (i_accept) begin
                r_count <= n_count;
            end
        end
        if (i_accept) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

`default_nettype wire

// ----- rtl/core/positional_ordered_list.sv -----
// Positional ordered list: a chain of CAPACITY cells holding signed 32-bit
// entries with insert and remove at front, back or index.
// Depends on pol_pkg, pol_ctrl and pol_cell.
`default_nettype none

// A request is taken on any clock edge with start high; busy never rises, so
// one request can be issued every cycle. On the taking edge an insert puts
// the entry at the index and moves the later cells back, a remove moves them
// forward, and the response beat appears on o_rsp with o_strobe high for
// exactly the next cycle. The response cannot be held off, so it must be
// captured in that cycle. A full list, an empty list or a bad index gives a
// status code and leaves the list unchanged.
module positional_ordered_list (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire pol_pkg::t_req i_req,
    output logic               o_strobe,
    output pol_pkg::t_rsp      o_rsp
);
    import pol_pkg::*;

    logic                    accept;
    t_cmd                    cmd;
    logic signed [VAL_W-1:0] cell_val [CAPACITY];
    logic signed [VAL_W-1:0] cell_tap [CAPACITY];
    logic signed [VAL_W-1:0] tap_or;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    pol_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_req    (i_req),
        .i_tap    (tap_or),
        .o_cmd    (cmd),
        .o_strobe (o_strobe),
        .o_rsp    (o_rsp)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] left;
        logic signed [VAL_W-1:0] right;

        if (g == 0) begin : g_first
            assign left = '0;
        end else begin : g_mid_l
            assign left = cell_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right = '0;
        end else begin : g_mid_r
            assign right = cell_val[g+1];
        end

        pol_cell u_cell (
            .i_clk   (i_clk),
            .i_cmd   (cmd),
            .i_pos   (CMP_W'(g)),
            .i_new   (i_req.value),
            .i_left  (left),
            .i_right (right),
            .o_val   (cell_val[g]),
            .o_tap   (cell_tap[g])
        );
    end

    always_comb begin
        tap_or = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            tap_or = tap_or | cell_tap[k];
        end
    end

endmodule

`default_nettype wire
